// ===== rtl/dcpt_pkg.sv =====
// shared types, constants and helpers for the dram command prerequisite tracker
package dcpt_pkg;

  localparam int RANKS    = 2;
  localparam int BANKS    = 8;
  localparam int ROW_BITS = 16;

  // fixed port widths of the request fields
  localparam int RANK_IN_W = 1;
  localparam int BANK_IN_W = 3;
  localparam int ROW_IN_W  = 16;
  localparam int CMD_W     = 4;
  localparam int PWR_W     = 2;

  localparam int SLOTS  = RANKS * BANKS;
  localparam int RANK_W = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACT  = 4'd0,
    CMD_PRE  = 4'd1,
    CMD_PREA = 4'd2,
    CMD_RD   = 4'd3,
    CMD_WR   = 4'd4,
    CMD_RDA  = 4'd5,
    CMD_WRA  = 4'd6,
    CMD_REF  = 4'd7,
    CMD_PDE  = 4'd8,
    CMD_PDX  = 4'd9,
    CMD_SRE  = 4'd10,
    CMD_SRX  = 4'd11
  } cmd_e;

  typedef enum logic [PWR_W-1:0] {
    PWR_UP    = 2'd0,
    PWR_ACTPD = 2'd1,
    PWR_PREPD = 2'd2,
    PWR_SR    = 2'd3
  } pwr_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } dcpt_ctrl_t;

  // wrap a rank index into range by repeated subtraction
  function automatic logic [RANK_W-1:0] wrap_rank(logic [RANK_IN_W-1:0] v);
    logic [4:0] t;
    t = 5'(v);
    for (int i = 0; i < (1 << RANK_IN_W); i++) begin
      if (t >= 5'(RANKS)) t = t - 5'(RANKS);
    end
    return RANK_W'(t);
  endfunction

  // wrap a bank index into range by repeated subtraction
  function automatic logic [BANK_W-1:0] wrap_bank(logic [BANK_IN_W-1:0] v);
    logic [4:0] t;
    t = 5'(v);
    for (int i = 0; i < (1 << BANK_IN_W); i++) begin
      if (t >= 5'(BANKS)) t = t - 5'(BANKS);
    end
    return BANK_W'(t);
  endfunction

  // keep the low ROW_BITS bits, zero-extending when the row is wider than the port
  function automatic logic [ROW_BITS-1:0] fit_row(logic [ROW_IN_W-1:0] v);
    logic [ROW_IN_W+ROW_BITS-1:0] ext;
    ext = {{ROW_BITS{1'b0}}, v};
    return ext[ROW_BITS-1:0];
  endfunction

endpackage

// ===== rtl/dcpt_ctrl.sv =====
// controller fsm: request acceptance, evaluation slot and result valid
module dcpt_ctrl
  import dcpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dcpt_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.commit  = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        // hold the evaluation until the result register is free
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("controller state not one-hot");
  a_capture_evals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> (state_q == S_EVAL)) else $error("capture not followed by eval");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.commit |=> out_valid_q) else $error("commit did not raise result valid");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.capture && ctrl_o.commit)) else $error("capture and commit together");
`endif

endmodule

// ===== rtl/dcpt_datapath.sv =====
// datapath: rank power and bank state, open-row memory, rule evaluation, result register
module dcpt_datapath
  import dcpt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcpt_ctrl_t           ctrl_i,
  input  logic                 action_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [RANK_IN_W-1:0] rank_index_i,
  input  logic [BANK_IN_W-1:0] bank_index_i,
  input  logic [ROW_IN_W-1:0]  row_index_i,
  output logic [CMD_W-1:0]     next_command_o,
  output logic                 row_hit_o,
  output logic                 issue_now_o,
  output logic [PWR_W-1:0]     rank_power_o
);

  // captured request
  logic                action_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [RANK_W-1:0]   rank_q;
  logic [BANK_W-1:0]   bank_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [ROW_BITS-1:0] row_q;

  logic [RANK_W-1:0]   rank_in;
  logic [BANK_W-1:0]   bank_in;
  logic [SLOT_W-1:0]   slot_in;

  // tracked state
  logic [PWR_W-1:0]    rank_state_q [RANKS];
  logic [BANKS-1:0]    bank_open_q  [RANKS];
  logic [BANKS-1:0]    bank_open_d  [RANKS];
  logic [PWR_W-1:0]    pwr_d;
  logic                mem_we;
  logic [ROW_BITS-1:0] row_mem [SLOTS];
  logic [ROW_BITS-1:0] row_rd_q;

  // evaluation
  logic [PWR_W-1:0]    pwr;
  logic                bank_is_open;
  logic                any_open;
  logic                hit;
  logic                pd;
  logic [CMD_W-1:0]    next_cmd;

  // result register
  logic [CMD_W-1:0]    next_command_q;
  logic                row_hit_q;
  logic                issue_now_q;
  logic [PWR_W-1:0]    rank_power_q;

  assign rank_in = wrap_rank(rank_index_i);
  assign bank_in = wrap_bank(bank_index_i);
  assign slot_in = SLOT_W'(rank_in) * SLOT_W'(BANKS) + SLOT_W'(bank_in);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      action_q <= action_i;
      cmd_q    <= command_i;
      rank_q   <= rank_in;
      bank_q   <= bank_in;
      slot_q   <= slot_in;
      row_q    <= fit_row(row_index_i);
    end
  end

  // open-row store, read at capture, written when an ACT is applied
  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[slot_q] <= row_q;
    if (ctrl_i.capture) row_rd_q <= row_mem[slot_in];
  end

  assign pwr          = rank_state_q[rank_q];
  assign bank_is_open = bank_open_q[rank_q][bank_q];
  assign any_open     = |bank_open_q[rank_q];
  assign hit          = bank_is_open && (row_rd_q == row_q);
  assign pd           = (pwr == PWR_ACTPD) || (pwr == PWR_PREPD);

  // prerequisite of the wanted command
  always_comb begin
    next_cmd = cmd_q;
    if (!action_q) begin
      unique case (cmd_q)
        CMD_RD, CMD_WR, CMD_RDA, CMD_WRA: begin
          priority if (pd)           next_cmd = CMD_PDX;
          else if (pwr == PWR_SR)    next_cmd = CMD_SRX;
          else if (!bank_is_open)    next_cmd = CMD_ACT;
          else if (!hit)             next_cmd = CMD_PRE;
          else                       next_cmd = cmd_q;
        end
        CMD_REF: next_cmd = any_open ? CMD_PREA : CMD_REF;
        CMD_PDE: next_cmd = (pwr == PWR_SR) ? CMD_SRX : CMD_PDE;
        CMD_SRE: next_cmd = pd ? CMD_PDX : CMD_SRE;
        default: next_cmd = cmd_q;
      endcase
    end
  end

  // state change of an issued command
  always_comb begin
    bank_open_d = bank_open_q;
    pwr_d       = pwr;
    mem_we      = 1'b0;
    if (action_q) begin
      unique case (cmd_q)
        CMD_ACT: begin
          bank_open_d[rank_q][bank_q] = 1'b1;
          mem_we = ctrl_i.commit;
        end
        CMD_PRE, CMD_RDA, CMD_WRA: bank_open_d[rank_q][bank_q] = 1'b0;
        CMD_PREA:         bank_open_d[rank_q] = '0;
        CMD_PDE:          pwr_d = any_open ? PWR_ACTPD : PWR_PREPD;
        CMD_PDX, CMD_SRX: pwr_d = PWR_UP;
        CMD_SRE:          pwr_d = PWR_SR;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RANKS; r++) begin
        rank_state_q[r] <= PWR_UP;
        bank_open_q[r]  <= '0;
      end
    end else if (ctrl_i.commit) begin
      rank_state_q[rank_q] <= pwr_d;
      bank_open_q          <= bank_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      next_command_q <= next_cmd;
      row_hit_q      <= hit;
      issue_now_q    <= (next_cmd == cmd_q);
      rank_power_q   <= pwr_d;
    end
  end

  assign next_command_o = next_command_q;
  assign row_hit_o      = row_hit_q;
  assign issue_now_o    = issue_now_q;
  assign rank_power_o   = rank_power_q;

`ifndef NO_ASSERTIONS
  a_issue_echoes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.commit && action_q) |=> issue_now_q) else $error("issue did not echo command");
  a_prea_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.commit && action_q && (cmd_q == CMD_PREA)) |=> (bank_open_q[$past(rank_q)] == '0))
    else $error("precharge-all left a bank open");
  a_act_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> bank_open_q[$past(rank_q)][$past(bank_q)]) else $error("activate did not open bank");
`endif

endmodule

// ===== rtl/dram_command_prereq_tracker.sv =====
// top level of the dram command prerequisite tracker
//
//  channel  signals                                        direction
//  in       in_valid_i/in_ready_o, action_i, command_i,    request in
//           rank_index_i, bank_index_i, row_index_i
//  out      out_valid_o/out_ready_i, next_command_o,       result out
//           row_hit_o, issue_now_o, rank_power_o
//
// one request at a time: an accept cycle (open-row memory read), then an
// evaluate cycle that updates bank and rank state and loads the result register.
// the evaluate cycle waits while the previous result is still held unread.
// reset clears all ranks to power up and all banks to closed; no clearing pass.
// in_ready_o is low from accept until the evaluate cycle has loaded the result.
module dram_command_prereq_tracker
  import dcpt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [RANK_IN_W-1:0] rank_index_i,
  input  logic [BANK_IN_W-1:0] bank_index_i,
  input  logic [ROW_IN_W-1:0]  row_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CMD_W-1:0]     next_command_o,
  output logic                 row_hit_o,
  output logic                 issue_now_o,
  output logic [PWR_W-1:0]     rank_power_o
);

  dcpt_ctrl_t ctrl;

  dcpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  dcpt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .action_i       (action_i),
    .command_i      (command_i),
    .rank_index_i   (rank_index_i),
    .bank_index_i   (bank_index_i),
    .row_index_i    (row_index_i),
    .next_command_o (next_command_o),
    .row_hit_o      (row_hit_o),
    .issue_now_o    (issue_now_o),
    .rank_power_o   (rank_power_o)
  );

endmodule
